// ----- hdl/hrd_pkg.sv -----
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and constants of the heartbeat rate detector
// Widths, register indexes, status codes and the queue item carried from the
// classifying front stage to the rate back stage.
// ----------------------------------------------------------------------------
package hrd_pkg;

    // sample width and derived baseline arithmetic widths
    localparam int SAMPLE_BITS = 10;
    localparam int SUM_W       = SAMPLE_BITS + 4;          // 9*base + sample
    localparam int DIV_SHIFT   = SUM_W + 4;                // reciprocal scale
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] BASE_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10);

    // register field widths
    localparam int DELTA_W = 10;
    localparam int MIN_W   = 13;
    localparam int MAX_W   = 16;
    localparam int RATE_W  = 10;
    localparam int TIME_W  = 32;
    localparam int IVAL_W  = 16;
    localparam int CMP_W   = ((SAMPLE_BITS > DELTA_W) ? SAMPLE_BITS : DELTA_W) + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_DELTA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH  = 3'd4;

    // rate arithmetic
    localparam logic [IVAL_W-1:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [RATE_W-1:0] RATE_MAX      = '1;
    localparam int DIV_STEPS = IVAL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // result status codes
    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_RATE  = 2'd1,
        ST_SHORT = 2'd2,
        ST_LONG  = 2'd3
    } t_status;

    // queue item from front to back
    typedef struct packed {
        t_status            status;
        logic [IVAL_W-1:0]  interval;
    } t_job;

    // configuration seen by each stage
    typedef struct packed {
        logic [DELTA_W-1:0] beat_delta;
        logic [MIN_W-1:0]   min_ival;
        logic [MAX_W-1:0]   max_ival;
    } t_front_cfg;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_low;
        logic [RATE_W-1:0]  rate_high;
    } t_band_cfg;

endpackage

// ----- hdl/heartbeat_rate_detector_core.sv -----
// ----------------------------------------------------------------------------
// heartbeat_rate_detector_core: pulse sample in, beat rate item out
// The front stage takes no new sample until the current one is queued at the
// end of its three-step sequence; an item with a rate also passes through the
// 16-step serial divider in the back stage.
// Reset (synchronous, active low) clears the sequencers, queue pointers, detector
// state and output valid flag, and restores the registers.
module heartbeat_rate_detector_core import hrd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample intake
    input  logic                    push,
    output logic                    full,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic [TIME_W-1:0]       i_time_ms,
    input  logic                    i_restart,
    // results
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_status,
    output logic [RATE_W-1:0]       o_rate,
    output logic                    o_in_band,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [DELTA_W-1:0]  r_beat_delta;
    logic [MIN_W-1:0]    r_min_ival;
    logic [MAX_W-1:0]    r_max_ival;
    logic [RATE_W-1:0]   r_rate_low;
    logic [RATE_W-1:0]   r_rate_high;

    t_front_cfg  front_cfg;
    t_band_cfg   band_cfg;
    logic        q_push, q_full, q_pop, q_empty;
    t_job        q_in_job, q_out_job;

    assign o_cfg_ready = 1'b1;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_delta <= DELTA_W'(30);
            r_min_ival   <= MIN_W'(400);
            r_max_ival   <= MAX_W'(1500);
            r_rate_low   <= RATE_W'(40);
            r_rate_high  <= RATE_W'(200);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BEAT_DELTA: r_beat_delta <= i_cfg_data[DELTA_W-1:0];
                CFG_MIN_IVAL:   r_min_ival   <= i_cfg_data[MIN_W-1:0];
                CFG_MAX_IVAL:   r_max_ival   <= i_cfg_data[MAX_W-1:0];
                CFG_RATE_LOW:   r_rate_low   <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_HIGH:  r_rate_high  <= i_cfg_data[RATE_W-1:0];
                default:        r_beat_delta <= r_beat_delta;
            endcase
        end
    end

    assign front_cfg.beat_delta = r_beat_delta;
    assign front_cfg.min_ival   = r_min_ival;
    assign front_cfg.max_ival   = r_max_ival;
    assign band_cfg.rate_low    = r_rate_low;
    assign band_cfg.rate_high   = r_rate_high;

    hrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_sample  (i_sample),
        .i_time_ms (i_time_ms),
        .i_restart (i_restart),
        .i_cfg     (front_cfg),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_job   (q_in_job)
    );

    hrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out_job)
    );

    hrd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .i_cfg     (band_cfg),
        .empty     (empty),
        .pop       (pop),
        .o_status  (o_status),
        .o_rate    (o_rate),
        .o_in_band (o_in_band)
    );

endmodule

// ----- hdl/hrd_front.sv -----
// ----------------------------------------------------------------------------
// hrd_front: sample intake and beat classification
// Tracks the baseline, the above flag and the last beat time, and hands one
// classified item per sample to the job queue.
// ----------------------------------------------------------------------------
module hrd_front import hrd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic [TIME_W-1:0]       i_time_ms,
    input  logic                    i_restart,
    input  t_front_cfg              i_cfg,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_job                    o_q_job
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_BASE  = 3'b010,
        F_CLASS = 3'b100
    } t_fstate;

    t_fstate                  r_state, n_state;
    logic [SAMPLE_BITS-1:0]   r_sample;
    logic [TIME_W-1:0]        r_time;
    logic                     r_restart;
    logic [PROD_W-1:0]        r_prod;
    logic [SAMPLE_BITS-1:0]   r_baseline;
    logic                     r_base_ready;
    logic                     r_was_above;
    logic [TIME_W-1:0]        r_last_beat;

    logic [SAMPLE_BITS-1:0]   base_in;
    logic [SUM_W-1:0]         base_sum;
    logic [SAMPLE_BITS-1:0]   base_new;
    logic signed [CMP_W-1:0]  s_ext, b_ext, d_ext;
    logic                     above;
    logic                     rise;
    logic [TIME_W-1:0]        interval;
    logic                     too_short;
    logic                     too_long;
    logic                     accept;
    logic                     commit;

    assign full   = (r_state != F_IDLE);
    assign accept = push && !full;
    assign commit = (r_state == F_CLASS) && !i_q_full;

    // seed on first sample or restart, then 9*base + sample
    assign base_in  = (r_restart || !r_base_ready) ? r_sample : r_baseline;
    assign base_sum = SUM_W'({base_in, 3'b000}) + SUM_W'(base_in) + SUM_W'(r_sample);

    // divide by ten through the registered reciprocal product
    assign base_new = r_prod[DIV_SHIFT +: SAMPLE_BITS];

    // signed distance above baseline against the delta
    assign s_ext = signed'(CMP_W'(r_sample));
    assign b_ext = signed'(CMP_W'(base_new));
    assign d_ext = signed'(CMP_W'(i_cfg.beat_delta));
    assign above = (s_ext - b_ext) > d_ext;
    assign rise  = !r_was_above && above;

    // beat interval, modulo 2^32
    assign interval  = r_time - r_last_beat;
    assign too_short = interval < TIME_W'(i_cfg.min_ival);
    assign too_long  = interval > TIME_W'(i_cfg.max_ival);

    // classify the item
    always_comb begin
        o_q_job.interval = interval[IVAL_W-1:0];
        o_q_job.status   = ST_NONE;
        if (rise && (r_last_beat != '0)) begin
            if (too_short) begin
                o_q_job.status = ST_SHORT;
            end else if (too_long) begin
                o_q_job.status = ST_LONG;
            end else begin
                o_q_job.status = ST_RATE;
            end
        end
    end
    assign o_q_push = commit;

    // advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_BASE;
            F_BASE:  n_state = F_CLASS;
            F_CLASS: if (commit) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the accepted item and the baseline product
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample  <= i_sample;
            r_time    <= i_time_ms;
            r_restart <= i_restart;
        end
        if (r_state == F_BASE) begin
            r_prod <= PROD_W'(base_sum) * PROD_W'(BASE_RECIP);
        end
    end

    // detector state: clear the edge flag and beat time on restart, update when the item is queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_base_ready <= 1'b0;
            r_was_above  <= 1'b0;
            r_last_beat  <= '0;
        end else if (r_state == F_BASE) begin
            r_base_ready <= 1'b1;
            if (r_restart) begin
                r_was_above <= 1'b0;
                r_last_beat <= '0;
            end
        end else if (commit) begin
            r_baseline <= base_new;
            if (rise && (r_last_beat != '0)) begin
                // edge flag is kept on any rejection or rate
                if (!too_short) begin
                    r_last_beat <= r_time;
                end
            end else begin
                if (rise) begin
                    r_last_beat <= r_time;
                end
                r_was_above <= above;
            end
        end
    end

endmodule

// ----- hdl/hrd_queue.sv -----
// ----------------------------------------------------------------------------
// hrd_queue: two-entry job queue
// Decouples the classifying front stage from the rate back stage.
// ----------------------------------------------------------------------------
module hrd_queue import hrd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_job  o_job
);

    t_job        r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // write the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/hrd_back.sv -----
// ----------------------------------------------------------------------------
// hrd_back: rate computation and result register
// Serial restoring divider for 60000 / interval, saturation, band check and
// the output register that holds the item until it is taken.
// ----------------------------------------------------------------------------
module hrd_back import hrd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_job               i_q_job,
    output logic               o_q_pop,
    input  t_band_cfg          i_cfg,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic [RATE_W-1:0]  o_rate,
    output logic               o_in_band
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_FIN  = 4'b0100,
        B_DONE = 4'b1000
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [IVAL_W-1:0]   r_rem;
    logic [IVAL_W-1:0]   r_quo;
    logic [IVAL_W-1:0]   r_div;
    logic [CNT_W-1:0]    r_cnt;
    t_status             r_res_status;
    logic [RATE_W-1:0]   r_res_rate;
    logic                r_res_band;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [RATE_W-1:0]   r_out_rate;
    logic                r_out_band;

    logic [IVAL_W:0]     rem_sh;
    logic [IVAL_W:0]     diff;
    logic [RATE_W-1:0]   rate_sat;
    logic                out_free;
    logic                load_out;

    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || pop;
    assign load_out = (r_state == B_DONE) && out_free;

    // one quotient bit per step
    assign rem_sh = {r_rem, r_quo[IVAL_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    // saturate the quotient to the rate width
    assign rate_sat = (r_quo[IVAL_W-1:RATE_W] != '0) ? RATE_MAX : r_quo[RATE_W-1:0];

    // advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_job.status != ST_RATE) begin
                        n_state = B_DONE;
                    end else if (i_q_job.interval == '0) begin
                        n_state = B_FIN;
                    end else begin
                        n_state = B_DIV;
                    end
                end
            end
            B_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = B_FIN;
            B_FIN:   n_state = B_DONE;
            B_DONE:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider datapath and result capture
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_res_status <= i_q_job.status;
                r_res_rate   <= '0;
                r_res_band   <= 1'b0;
                r_rem        <= '0;
                r_div        <= i_q_job.interval;
                r_cnt        <= '0;
                // zero interval: force a quotient that saturates
                r_quo        <= (i_q_job.interval == '0) ? '1 : MS_PER_MINUTE;
            end
            B_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_quo <= {r_quo[IVAL_W-2:0], !diff[IVAL_W]};
                r_rem <= diff[IVAL_W] ? rem_sh[IVAL_W-1:0] : diff[IVAL_W-1:0];
            end
            B_FIN: begin
                r_res_rate <= rate_sat;
                r_res_band <= (rate_sat >= i_cfg.rate_low) && (rate_sat <= i_cfg.rate_high);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_rate   <= r_res_rate;
            r_out_band   <= r_res_band;
        end
    end

    assign empty     = !r_out_valid;
    assign o_status  = r_out_status;
    assign o_rate    = r_out_rate;
    assign o_in_band = r_out_band;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for heartbeat_rate_detector_core
// Sends pulse-sensor samples through the intake queue and checks every result
// item against a cycle-free predictor of the baseline, edge and interval
// logic. Covers directed corner sequences, saturation, register extremes,
// randomised pulse trains with idling on both sides, and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
    import hrd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 30;
    localparam int MINUTE_MS   = 60000;
    localparam int BPM_CEIL    = 1023;

    typedef struct packed {
        t_status             status;
        logic [RATE_W-1:0]   rate;
        logic                in_band;
    } t_beat_report;

    // clock and block inputs, all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample    = '0;
    logic [TIME_W-1:0]      i_time_ms   = '0;
    logic                   i_restart   = 1'b0;
    logic                   pop         = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_BEAT_DELTA;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    logic                   full;
    logic                   empty;
    logic [1:0]             o_status;
    logic [RATE_W-1:0]      o_rate;
    logic                   o_in_band;
    logic                   o_cfg_ready;

    // predictor registers and state
    logic [DELTA_W-1:0]     delta_reg     = 10'd30;
    logic [MIN_W-1:0]       min_ival_reg  = 13'd400;
    logic [MAX_W-1:0]       max_ival_reg  = 16'd1500;
    logic [RATE_W-1:0]      band_low_reg  = 10'd40;
    logic [RATE_W-1:0]      band_high_reg = 10'd200;
    logic [SAMPLE_BITS-1:0] base_level    = '0;
    logic                   base_seeded   = 1'b0;
    logic                   pulse_high    = 1'b0;
    logic [TIME_W-1:0]      beat_stamp    = '0;

    t_beat_report reports_due[$];
    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  idling_on   = 1'b1;
    int  hold_req    = 0;
    int  hold_served = 0;
    int  hold_left   = 0;
    int  rx_idle     = 0;

    heartbeat_rate_detector_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .i_time_ms   (i_time_ms),
        .i_restart   (i_restart),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_rate      (o_rate),
        .o_in_band   (o_in_band),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the baseline and edge state for one sample and return its report
    function automatic t_beat_report predict_beat(input logic [SAMPLE_BITS-1:0] smp,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic restart);
        t_beat_report rep;
        int acc;
        logic above;
        logic [TIME_W-1:0] gap;
        logic [31:0] bpm;
        rep = '{ST_NONE, '0, 1'b0};
        if (restart) begin
            base_level  = '0;
            base_seeded = 1'b0;
            pulse_high  = 1'b0;
            beat_stamp  = '0;
        end
        if (!base_seeded) begin
            base_level  = smp;
            base_seeded = 1'b1;
        end
        acc = int'(base_level) * 9 + int'(smp);
        base_level = SAMPLE_BITS'(acc / 10);
        above = (int'(smp) - int'(base_level)) > int'(delta_reg);
        if (!pulse_high && above) begin
            // a stamp of zero means no beat stored, even after a beat at time zero
            if (beat_stamp != '0) begin
                gap = now - beat_stamp;
                if (gap < TIME_W'(min_ival_reg)) begin
                    rep.status = ST_SHORT;
                    return rep;
                end
                beat_stamp = now;
                if (gap > TIME_W'(max_ival_reg)) begin
                    rep.status = ST_LONG;
                    return rep;
                end
                bpm = (gap == '0) ? BPM_CEIL : MINUTE_MS / gap;
                if (bpm > BPM_CEIL) bpm = BPM_CEIL;
                rep.status  = ST_RATE;
                rep.rate    = RATE_W'(bpm);
                rep.in_band = (bpm >= band_low_reg) && (bpm <= band_high_reg);
                return rep;
            end
            beat_stamp = now;
        end
        pulse_high = above;
        return rep;
    endfunction

    // Offer one sample, wait for the intake handshake, then queue its report
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp,
                               input logic [TIME_W-1:0] stamp, input logic restart);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_sample  <= smp;
        i_time_ms <= stamp;
        i_restart <= restart;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        reports_due.push_back(predict_beat(smp, stamp, restart));
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BEAT_DELTA: delta_reg     = data[DELTA_W-1:0];
            CFG_MIN_IVAL:   min_ival_reg  = data[MIN_W-1:0];
            CFG_MAX_IVAL:   max_ival_reg  = data[MAX_W-1:0];
            CFG_RATE_LOW:   band_low_reg  = data[RATE_W-1:0];
            CFG_RATE_HIGH:  band_high_reg = data[RATE_W-1:0];
            default: ;
        endcase
    endtask

    // Write all five registers plus one unused index, which must be ignored
    task automatic apply_config(input logic [15:0] delta, input logic [15:0] min_ival,
                                input logic [15:0] max_ival, input logic [15:0] low,
                                input logic [15:0] high);
        write_reg(CFG_BEAT_DELTA, delta);
        write_reg(CFG_MIN_IVAL, min_ival);
        write_reg(CFG_MAX_IVAL, max_ival);
        write_reg(CFG_RATE_LOW, low);
        write_reg(CFG_RATE_HIGH, high);
        write_reg(CFG_RATE_HIGH + CFG_IDX_W'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering items and wait until every report has come back
    task automatic finish_phase();
        push <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Pulse train: a noisy floor with spikes at random intervals around the
    // configured window, plus the odd stray sample
    task automatic drive_pulse_train(input int n_items);
        logic [TIME_W-1:0] stamp;
        int to_beat, spike_left, floor_lvl, swing, lo, hi, smp, step;
        stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                            : $urandom;
        swing = int'(delta_reg) * 11 / 10 + int'($urandom_range(10, 300));
        if (swing > 1023) swing = 1023;
        floor_lvl  = $urandom_range(0, 1023 - swing);
        to_beat    = $urandom_range(0, 1000);
        spike_left = 0;
        send_sample(SAMPLE_BITS'(floor_lvl), stamp, 1'b1);
        for (int k = 1; k < n_items; k++) begin
            if ($urandom_range(0, 32) == 0) begin
                send_sample(SAMPLE_BITS'($urandom), $urandom, $urandom_range(0, 3) == 0);
            end else begin
                step    = $urandom_range(20, 80);
                stamp   = stamp + TIME_W'(step);
                to_beat = to_beat - step;
                if (to_beat <= 0 && spike_left == 0) begin
                    lo = int'(min_ival_reg) / 2 + 40;
                    hi = int'(max_ival_reg) + int'(max_ival_reg) / 4 + 100;
                    if (hi > 6000) hi = 6000;
                    if (hi < lo + 100) hi = lo + 100;
                    to_beat    = $urandom_range(lo, hi);
                    spike_left = $urandom_range(1, 3);
                end
                smp = floor_lvl + int'($urandom_range(0, 8)) - 4;
                if (spike_left > 0) begin
                    smp = smp + swing;
                    spike_left--;
                end
                if (smp < 0) smp = 0;
                if (smp > 1023) smp = 1023;
                send_sample(SAMPLE_BITS'(smp), stamp, 1'b0);
            end
        end
    endtask

    // Reset registers: first beat at time zero, short, long, band edges, wrap
    task automatic test_default_registers();
        send_sample(10'd0,    32'hFFFF_FFFF, 1'b1);
        send_sample(10'd1023, 32'd0,    1'b0);
        send_sample(10'd0,    32'd50,   1'b0);
        send_sample(10'd1023, 32'd600,  1'b0);
        send_sample(10'd0,    32'd650,  1'b0);
        send_sample(10'd1023, 32'd1200, 1'b0);
        send_sample(10'd0,    32'd1250, 1'b0);
        send_sample(10'd1023, 32'd1300, 1'b0);
        send_sample(10'd1023, 32'd1350, 1'b0);
        send_sample(10'd0,    32'd1400, 1'b0);
        send_sample(10'd1023, 32'd3500, 1'b0);
        send_sample(10'd0,    32'd3550, 1'b0);
        send_sample(10'd1023, 32'd3900, 1'b0);
        send_sample(10'd0,    32'd3950, 1'b0);
        send_sample(10'd1023, 32'd5400, 1'b0);
        send_sample(10'd0,    32'd5450, 1'b0);
        send_sample(10'd1023, 32'hFFFF_FE00, 1'b0);
        send_sample(10'd0,    32'hFFFF_FF00, 1'b0);
        send_sample(10'd1023, 32'h0000_0100, 1'b0);
        send_sample(10'd512,  32'd7,    1'b1);
        send_sample(10'd1023, 32'd60,   1'b0);
        finish_phase();
    endtask

    // Zero interval and overflowing rate both saturate
    task automatic test_rate_saturation();
        apply_config(16'd0, 16'd0, 16'd65535, 16'd0, 16'd1023);
        send_sample(10'd0,    32'd100, 1'b1);
        send_sample(10'd1023, 32'd100, 1'b0);
        send_sample(10'd0,    32'd100, 1'b0);
        send_sample(10'd1023, 32'd100, 1'b0);
        send_sample(10'd0,    32'd110, 1'b0);
        send_sample(10'd1023, 32'd130, 1'b0);
        finish_phase();
    endtask

    // Random trains over extreme, inverted, over-wide and typical settings
    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_config(16'd0, 16'd100, 16'd60000, 16'd0, 16'd600);
                1: apply_config(16'd1023, 16'd5000, 16'd100, 16'd600, 16'd0);
                2: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
                default: apply_config(16'($urandom_range(0, 120)),
                                      16'($urandom_range(100, 1200)),
                                      16'($urandom_range(600, 3000)),
                                      16'($urandom_range(0, 100)),
                                      16'($urandom_range(100, 600)));
            endcase
            drive_pulse_train((ph == 1) ? 60 : 120);
            finish_phase();
        end
    endtask

    // Hold the result side off while samples keep coming, so the intake fills
    task automatic test_input_stall();
        apply_config(16'd30, 16'd400, 16'd1500, 16'd40, 16'd200);
        idling_on = 1'b0;
        hold_req <= hold_req + 1;
        drive_pulse_train(60);
        finish_phase();
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_streaming();
        apply_config(16'($urandom_range(10, 60)), 16'($urandom_range(200, 500)),
                     16'($urandom_range(1000, 2500)), 16'($urandom_range(30, 60)),
                     16'($urandom_range(120, 250)));
        idling_on = 1'b0;
        drive_pulse_train(60);
        finish_phase();
    endtask

    // Stimulus sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_registers();
        test_rate_saturation();
        test_random_settings();
        test_input_stall();
        test_streaming();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: long hold on request, random idle bursts otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_served != hold_req) begin
            hold_served = hold_req;
            hold_left   = LONG_HOLD - 1;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle--;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rx_idle = $urandom_range(1, 9) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Compare each accepted result item with the oldest report due
    always @(posedge i_clk) begin
        t_beat_report want;
        if (i_rst_n && pop && !empty) begin
            if (reports_due.size() == 0) begin
                $error("result item with no report due: status %0d rate %0d in_band %0d",
                       o_status, o_rate, o_in_band);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_rate !== want.rate) begin
                    $error("rate: expected %0d, got %0d", want.rate, o_rate);
                    mismatches++;
                end
                if (o_in_band !== want.in_band) begin
                    $error("in_band: expected %0d, got %0d", want.in_band, o_in_band);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
hdl/hrd_pkg.sv
hdl/hrd_front.sv
hdl/hrd_queue.sv
hdl/hrd_back.sv
hdl/heartbeat_rate_detector_core.sv
verif/tb.sv
